// ===== rtl/ddalr_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
// Used by every module of the block; depends on nothing.
package ddalr_pkg;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int CUR_BITS     = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS    = FRAC_BITS + 2;
    localparam int QUO_BITS     = FRAC_BITS + 1;
    localparam int NUM_BITS     = COORD_BITS + FRAC_BITS + 1;
    localparam int STEPS_BITS   = COORD_BITS + 1;
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int ADDR_BITS    = 24;
    localparam int COLOR_BITS   = 32;
    localparam int PROD_BITS    = COORD_BITS + CFG_BITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        ST_RUN = 1'b0,
        ST_DIV = 1'b1
    } back_state_t;

    // Classified command as it waits in the queue
    typedef struct packed {
        logic                  is_start;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic                  neg_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] mag_x;
        logic [COORD_BITS-1:0] mag_y;
        logic [COORD_BITS-1:0] steps;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic                  start;
        logic [NUM_BITS-1:0]   num_x;
        logic [NUM_BITS-1:0]   num_y;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quo_x;
        logic [QUO_BITS-1:0] quo_y;
    } div_rsp_t;

endpackage

// ===== rtl/dda_line_rasterizer_top.sv =====
// A step tick passes through the command queue and then the output register.
// Throughput: one tick per cycle while the output is not stalled; a start command of a
// nonzero-length line holds the pixel engine while the bit-serial divider runs.
// Reset (rst_n, async, active low): no line active, queue and output empty,
// screen_width 640, screen_height 480.
module dda_line_rasterizer_top
    import ddalr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [COLOR_BITS-1:0]        line_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [ADDR_BITS-1:0]         pixel_address,
    output logic [COLOR_BITS-1:0]        pixel_color,
    output logic                         write_enable,
    output logic                         last_pixel
);

    logic     push;
    logic     pop;
    logic     full;
    logic     head_valid;
    cmd_t     cmd;
    cmd_t     head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    ddalr_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .queue_full (full),
        .push       (push),
        .cmd        (cmd)
    );

    ddalr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd_in     (cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (full)
    );

    ddalr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ddalr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .write_enable  (write_enable),
        .last_pixel    (last_pixel)
    );

endmodule

// ===== rtl/ddalr_front.sv =====
// Front end: input handshake and command classification (deltas, magnitudes, step count).
// Depends on ddalr_pkg.
module ddalr_front
    import ddalr_pkg::*;
(
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [COLOR_BITS-1:0]        line_color,
    input  logic                         queue_full,
    output logic                         push,
    output cmd_t                         cmd
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   abs_x;
    logic [COORD_BITS:0]   abs_y;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        dx    = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy    = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        abs_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        abs_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        mag_x = abs_x[COORD_BITS-1:0];
        mag_y = abs_y[COORD_BITS-1:0];

        cmd.is_start = (op_t'(opcode) == OP_START);
        cmd.sx       = start_x;
        cmd.sy       = start_y;
        cmd.neg_x    = dx[COORD_BITS];
        cmd.neg_y    = dy[COORD_BITS];
        cmd.mag_x    = mag_x;
        cmd.mag_y    = mag_y;
        cmd.steps    = (mag_x > mag_y) ? mag_x : mag_y;
        cmd.color    = line_color;
    end

endmodule

// ===== rtl/ddalr_queue.sv =====
// Short command queue between the front end and the pixel engine.
// Depends on ddalr_pkg.
module ddalr_queue
    import ddalr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output logic head_valid,
    output cmd_t head,
    output logic full
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/ddalr_divider.sv =====
// Two-lane restoring divider for the per-step increments, one quotient bit per cycle.
// Depends on ddalr_pkg.
module ddalr_divider
    import ddalr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [DIV_CNT_BITS-1:0] count_reg;
    logic [DIV_CNT_BITS-1:0] count_next;
    logic [COORD_BITS-1:0]   divisor_reg;
    logic [COORD_BITS-1:0]   divisor_next;
    logic [COORD_BITS-1:0]   rem_x_reg;
    logic [COORD_BITS-1:0]   rem_x_next;
    logic [COORD_BITS-1:0]   rem_y_reg;
    logic [COORD_BITS-1:0]   rem_y_next;
    logic [NUM_BITS-1:0]     quo_x_reg;
    logic [NUM_BITS-1:0]     quo_x_next;
    logic [NUM_BITS-1:0]     quo_y_reg;
    logic [NUM_BITS-1:0]     quo_y_next;
    logic [COORD_BITS:0]     res_x;
    logic [COORD_BITS:0]     res_y;

    // Returns {quotient bit, new remainder}
    function automatic logic [COORD_BITS:0] div_trial(
        input logic [COORD_BITS-1:0] rem,
        input logic                  bit_in,
        input logic [COORD_BITS-1:0] d
    );
        logic [COORD_BITS:0] trial;
        logic [COORD_BITS:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
        begin
            div_trial = {1'b1, diff[COORD_BITS-1:0]};
        end
        else
        begin
            div_trial = {1'b0, trial[COORD_BITS-1:0]};
        end
    endfunction

    assign rsp.done  = done_reg;
    assign rsp.quo_x = quo_x_reg[QUO_BITS-1:0];
    assign rsp.quo_y = quo_y_reg[QUO_BITS-1:0];

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        divisor_next = divisor_reg;
        rem_x_next   = rem_x_reg;
        rem_y_next   = rem_y_reg;
        quo_x_next   = quo_x_reg;
        quo_y_next   = quo_y_reg;
        res_x        = div_trial(rem_x_reg, quo_x_reg[NUM_BITS-1], divisor_reg);
        res_y        = div_trial(rem_y_reg, quo_y_reg[NUM_BITS-1], divisor_reg);
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            divisor_next = req.divisor;
            rem_x_next   = '0;
            rem_y_next   = '0;
            quo_x_next   = req.num_x;
            quo_y_next   = req.num_y;
        end
        else if (busy_reg)
        begin
            // shift the dividend out on top while the quotient bits enter below
            rem_x_next = res_x[COORD_BITS-1:0];
            rem_y_next = res_y[COORD_BITS-1:0];
            quo_x_next = {quo_x_reg[NUM_BITS-2:0], res_x[COORD_BITS]};
            quo_y_next = {quo_y_reg[NUM_BITS-2:0], res_y[COORD_BITS]};
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_BITS'(NUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_x_reg   <= rem_x_next;
        rem_y_reg   <= rem_y_next;
        quo_x_reg   <= quo_x_next;
        quo_y_reg   <= quo_y_next;
    end

endmodule

// ===== rtl/ddalr_back.sv =====
// Pixel engine: line state, screen bounds, address generation and output register.
// Depends on ddalr_pkg; drives the divider through div_req_t / div_rsp_t.
module ddalr_back
    import ddalr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         head_valid,
    input  cmd_t                         head,
    output logic                         pop,
    output div_req_t                     div_req,
    input  div_rsp_t                     div_rsp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [ADDR_BITS-1:0]         pixel_address,
    output logic [COLOR_BITS-1:0]        pixel_color,
    output logic                         write_enable,
    output logic                         last_pixel
);

    back_state_t           state_reg;
    back_state_t           state_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   width_next;
    logic [CFG_BITS-1:0]   height_reg;
    logic [CFG_BITS-1:0]   height_next;

    logic [CUR_BITS-1:0]   cur_x_reg;
    logic [CUR_BITS-1:0]   cur_x_next;
    logic [CUR_BITS-1:0]   cur_y_reg;
    logic [CUR_BITS-1:0]   cur_y_next;
    logic [STEP_BITS-1:0]  step_x_reg;
    logic [STEP_BITS-1:0]  step_x_next;
    logic [STEP_BITS-1:0]  step_y_reg;
    logic [STEP_BITS-1:0]  step_y_next;
    logic [STEPS_BITS-1:0] steps_left_reg;
    logic [STEPS_BITS-1:0] steps_left_next;
    logic [COLOR_BITS-1:0] color_reg;
    logic [COLOR_BITS-1:0] color_next;
    logic                  neg_x_reg;
    logic                  neg_x_next;
    logic                  neg_y_reg;
    logic                  neg_y_next;

    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] px_next;
    logic [COORD_BITS-1:0] py_reg;
    logic [COORD_BITS-1:0] py_next;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  addr_next;
    logic [COLOR_BITS-1:0] pcolor_reg;
    logic [COLOR_BITS-1:0] pcolor_next;
    logic                  we_reg;
    logic                  we_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  out_free;
    logic                  emit;
    logic [COORD_BITS:0]   fx;
    logic [COORD_BITS:0]   fy;
    logic                  in_bounds;
    logic [PROD_BITS-1:0]  prod;
    logic [PROD_BITS-1:0]  sum;
    logic [STEP_BITS-1:0]  qx_ext;
    logic [STEP_BITS-1:0]  qy_ext;

    assign out_valid     = out_valid_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = pcolor_reg;
    assign write_enable  = we_reg;
    assign last_pixel    = last_reg;

    assign out_free = !out_valid_reg || out_ready;

    // Floor of the fixed-point position is the arithmetic top slice
    assign fx = cur_x_reg[CUR_BITS-1:FRAC_BITS];
    assign fy = cur_y_reg[CUR_BITS-1:FRAC_BITS];

    always_comb
    begin
        in_bounds = !fx[COORD_BITS] && !fy[COORD_BITS]
                    && (32'(fx[COORD_BITS-1:0]) < 32'(width_reg))
                    && (32'(fy[COORD_BITS-1:0]) < 32'(height_reg));
        prod      = PROD_BITS'(fy[COORD_BITS-1:0]) * PROD_BITS'(width_reg);
        sum       = prod + PROD_BITS'(fx[COORD_BITS-1:0]);
        qx_ext    = {1'b0, div_rsp.quo_x};
        qy_ext    = {1'b0, div_rsp.quo_y};
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        steps_left_next = steps_left_reg;
        color_next      = color_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        addr_next       = addr_reg;
        pcolor_next     = pcolor_reg;
        we_next         = we_reg;
        last_next       = last_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        div_req.start   = 1'b0;
        div_req.num_x   = {1'b0, head.mag_x, {FRAC_BITS{1'b0}}}
                          + NUM_BITS'(head.steps >> 1);
        div_req.num_y   = {1'b0, head.mag_y, {FRAC_BITS{1'b0}}}
                          + NUM_BITS'(head.steps >> 1);
        div_req.divisor = head.steps;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                CFG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (head_valid)
                begin
                    if (head.is_start)
                    begin
                        // load the new line and drop whatever was in progress
                        pop             = 1'b1;
                        active_next     = 1'b1;
                        cur_x_next      = {head.sx[COORD_BITS-1], head.sx, {FRAC_BITS{1'b0}}};
                        cur_y_next      = {head.sy[COORD_BITS-1], head.sy, {FRAC_BITS{1'b0}}};
                        steps_left_next = STEPS_BITS'(head.steps);
                        color_next      = head.color;
                        neg_x_next      = head.neg_x;
                        neg_y_next      = head.neg_y;
                        if (head.steps == '0)
                        begin
                            step_x_next = '0;
                            step_y_next = '0;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    else if (!active_reg)
                    begin
                        pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        emit           = 1'b1;
                        out_valid_next = 1'b1;
                        px_next        = fx[COORD_BITS-1:0];
                        py_next        = fy[COORD_BITS-1:0];
                        addr_next      = in_bounds ? ADDR_BITS'(sum) : '0;
                        pcolor_next    = color_reg;
                        we_next        = in_bounds;
                        last_next      = (steps_left_reg == '0);
                        if (steps_left_reg == '0)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            steps_left_next = steps_left_reg - 1'b1;
                            cur_x_next = cur_x_reg
                                + {{(CUR_BITS-STEP_BITS){step_x_reg[STEP_BITS-1]}}, step_x_reg};
                            cur_y_next = cur_y_reg
                                + {{(CUR_BITS-STEP_BITS){step_y_reg[STEP_BITS-1]}}, step_y_reg};
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_x_next = neg_x_reg ? (~qx_ext + 1'b1) : qx_ext;
                    step_y_next = neg_y_reg ? (~qy_ext + 1'b1) : qy_ext;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        step_x_reg     <= step_x_next;
        step_y_reg     <= step_y_next;
        steps_left_reg <= steps_left_next;
        color_reg      <= color_next;
        neg_x_reg      <= neg_x_next;
        neg_y_reg      <= neg_y_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        addr_reg       <= addr_next;
        pcolor_reg     <= pcolor_next;
        we_reg         <= we_next;
        last_reg       <= last_next;
    end

`ifndef NO_ASSERTIONS
    a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> !pop)
        else $error("queue popped during increment division");

    a_emit_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg && $past(active_reg))
        else $error("pixel emitted without an active line");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> div_req.divisor != '0)
        else $error("division started with zero step count");
`endif

endmodule

// ===== tb/sv/tb_dda_line_rasterizer_top.sv =====
// Self-checking testbench for dda_line_rasterizer_top: drives start and tick words,
// predicts every emitted pixel and compares it field by field.
// Depends on ddalr_pkg and the rasterizer RTL.
module tb_dda_line_rasterizer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ddalr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 48;
    localparam int PHASE_WORDS    = 400;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [ADDR_BITS-1:0]         addr;
        logic [COLOR_BITS-1:0]        color;
        logic                         we;
        logic                         last;
    } pixel_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_IDX_BITS-1:0]      cfg_index;
    logic [CFG_BITS-1:0]          cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        line_color;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]         pixel_address;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         write_enable;
    logic                         last_pixel;

    // Rasterizer state as the predictor sees it
    logic signed [CUR_BITS-1:0]  pos_x;
    logic signed [CUR_BITS-1:0]  pos_y;
    logic signed [STEP_BITS-1:0] inc_x;
    logic signed [STEP_BITS-1:0] inc_y;
    logic [STEPS_BITS-1:0]       pixels_remaining;
    logic [COLOR_BITS-1:0]       line_rgba;
    logic                        drawing;
    logic [CFG_BITS-1:0]         screen_w;
    logic [CFG_BITS-1:0]         screen_h;

    pixel_t expected_pixels[$];
    int     mismatches;
    int     words_sent;
    int     lines_started;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     stall_cycles;

    dda_line_rasterizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .write_enable  (write_enable),
        .last_pixel    (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int line_steps(int sx, int sy, int ex, int ey);
        int ax;
        int ay;
        ax = (ex - sx < 0) ? sx - ex : ex - sx;
        ay = (ey - sy < 0) ? sy - ey : ey - sy;
        return (ax > ay) ? ax : ay;
    endfunction

    // Fixed-point increment, rounded to nearest with ties away from zero
    function automatic logic signed [STEP_BITS-1:0] slope_inc(int d, int steps);
        longint mag;
        longint q;
        if (steps == 0)
            return '0;
        mag = (d < 0) ? -d : d;
        q = ((mag << FRAC_BITS) + steps / 2) / steps;
        if (d < 0)
            q = -q;
        return STEP_BITS'(q);
    endfunction

    task automatic model_word(op_t op, int sx, int sy, int ex, int ey,
                              logic [COLOR_BITS-1:0] color);
        int                                 steps;
        int                                 fxi;
        int                                 fyi;
        int                                 wd;
        int                                 ht;
        logic signed [CUR_BITS-FRAC_BITS-1:0] fx;
        logic signed [CUR_BITS-FRAC_BITS-1:0] fy;
        pixel_t                             p;
        if (op == OP_START)
        begin
            steps = line_steps(sx, sy, ex, ey);
            inc_x = slope_inc(ex - sx, steps);
            inc_y = slope_inc(ey - sy, steps);
            pos_x = CUR_BITS'(sx * (1 << FRAC_BITS));
            pos_y = CUR_BITS'(sy * (1 << FRAC_BITS));
            pixels_remaining = STEPS_BITS'(steps);
            line_rgba = color;
            drawing = 1'b1;
            words_sent++;
            lines_started++;
        end
        else if (drawing)
        begin
            // floor of the fixed-point position
            fx = pos_x[CUR_BITS-1:FRAC_BITS];
            fy = pos_y[CUR_BITS-1:FRAC_BITS];
            fxi = int'(fx);
            fyi = int'(fy);
            wd = int'(screen_w);
            ht = int'(screen_h);
            p.we = fxi >= 0 && fyi >= 0 && fxi < wd && fyi < ht;
            p.addr = p.we ? ADDR_BITS'(fyi * wd + fxi) : '0;
            p.x = fx[COORD_BITS-1:0];
            p.y = fy[COORD_BITS-1:0];
            p.color = line_rgba;
            p.last = (pixels_remaining == 0);
            expected_pixels.push_back(p);
            if (p.last)
                drawing = 1'b0;
            else
            begin
                pixels_remaining = pixels_remaining - 1'b1;
                pos_x = pos_x + inc_x;
                pos_y = pos_y + inc_y;
            end
            words_sent++;
        end
    endtask

    // Entered before a falling edge, returns at the accepting rising edge
    task automatic send_word(op_t op, int sx, int sy, int ex, int ey,
                             logic [COLOR_BITS-1:0] color);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        start_x    <= COORD_BITS'(sx);
        start_y    <= COORD_BITS'(sy);
        end_x      <= COORD_BITS'(ex);
        end_y      <= COORD_BITS'(ey);
        line_color <= color;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_word(op, sx, sy, ex, ey, color);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, int'($urandom_range(0, 4095)) - 2048,
                  int'($urandom_range(0, 4095)) - 2048,
                  int'($urandom_range(0, 4095)) - 2048,
                  int'($urandom_range(0, 4095)) - 2048, $urandom());
    endtask

    task automatic draw_line(int sx, int sy, int ex, int ey,
                             logic [COLOR_BITS-1:0] color, int ticks);
        send_word(OP_START, sx, sy, ex, ey, color);
        repeat (ticks)
            send_tick();
    endtask

    // Hold the sender until every pixel is back and the divider has settled
    task automatic drain_pixels();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_screen(int w, int h);
        drain_pixels();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= CFG_BITS'(w);
        @(negedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= CFG_BITS'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        screen_w = CFG_BITS'(w);
        screen_h = CFG_BITS'(h);
    endtask

    function automatic int clamp_coord(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic int pick_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom_range(0, 700);
        if (pick < 7)
            return int'($urandom_range(0, 7)) - 4;
        if (pick == 7)
            return $urandom_range(0, 1) ? 2047 - int'($urandom_range(0, 3))
                                        : -2048 + int'($urandom_range(0, 3));
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    task automatic random_line();
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int ticks;
        int pick;
        sx = pick_coord();
        sy = pick_coord();
        pick = $urandom_range(0, 99);
        reach = (pick < 80) ? 8 : ((pick < 96) ? 64 : 600);
        if ($urandom_range(0, 19) == 0)
        begin
            ex = sx;
            ey = sy;
        end
        else
        begin
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
        end
        ticks = line_steps(sx, sy, ex, ey) + 1;
        pick = $urandom_range(0, 99);
        // abandon early, or run past the end with ticks that draw nothing
        if (pick < 10)
            ticks = $urandom_range(0, ticks - 1);
        else if (pick < 18)
            ticks = ticks + int'($urandom_range(1, 3));
        draw_line(sx, sy, ex, ey, $urandom(), ticks);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_tick();
        draw_line(5, 7, 5, 7, 32'hFFFF_FFFF, 2);
        draw_line(-2048, 2047, 2047, -2048, 32'h0000_0000, 2);
        draw_line(0, 0, 3, -5, 32'hA5A5_5A5A, 6);
        draw_line(-2, 478, 2, 481, 32'h1234_5678, 5);
        draw_line(639, 0, 641, 1, 32'h5A5A_A5A5, 3);
    endtask

    task automatic test_screen_extremes();
        write_screen(1, 1);
        draw_line(-1, -1, 2, 2, $urandom(), 4);
        write_screen(0, 0);
        draw_line(0, 0, 1, 0, $urandom(), 2);
        write_screen(4096, 4096);
        draw_line(2047, 2047, 2044, 2045, $urandom(), 4);
        draw_line(0, 2047, 5, 2040, $urandom(), 8);
    endtask

    task automatic test_random_lines(int send_pct, int recv_pct, int w, int h);
        int first_word;
        write_screen(w, h);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_word = words_sent;
        while (words_sent - first_word < PHASE_WORDS)
        begin
            case ($urandom_range(0, 49))
                0:       drain_pixels();
                1, 2:    send_tick();
                default: random_line();
            endcase
        end
    endtask

    // Increments rounded up in magnitude carry the last floor just past -2048
    task automatic test_drift_lines();
        write_screen(4096, 4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        draw_line(0, -2046, 3, -2048, $urandom(), 4);
        draw_line(-2046, 0, -2048, 3, $urandom(), 4);
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.x = pixel_x;
            got.y = pixel_y;
            got.addr = pixel_address;
            got.color = pixel_color;
            got.we = write_enable;
            got.last = last_pixel;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: pixel x=%0d y=%0d arrived with nothing pending",
                             $time, got.x, got.y);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
                    got.color !== want.color || got.we !== want.we ||
                    got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: expected x=%0d y=%0d addr=%h color=%h we=%b last=%b,",
                                  " got x=%0d y=%0d addr=%h color=%h we=%b last=%b"},
                                 $time, want.x, want.y, want.addr, want.color, want.we,
                                 want.last, got.x, got.y, got.addr, got.color, got.we,
                                 got.last);
                end
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles, %0d pixels outstanding",
                 WATCHDOG_LIMIT, expected_pixels.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SCREEN_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        opcode     = OP_START;
        start_x    = '0;
        start_y    = '0;
        end_x      = '0;
        end_y      = '0;
        line_color = '0;
        pos_x = '0;
        pos_y = '0;
        inc_x = '0;
        inc_y = '0;
        pixels_remaining = '0;
        line_rgba = '0;
        drawing = 1'b0;
        screen_w = WIDTH_RESET;
        screen_h = HEIGHT_RESET;
        mismatches = 0;
        words_sent = 0;
        lines_started = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_screen_extremes();
        test_random_lines(10, 76, 640, 480);
        test_random_lines(76, 10, 8191, 8191);
        test_random_lines(0, 0, $urandom_range(1, 4096), $urandom_range(1, 4096));
        test_drift_lines();
        drain_pixels();

        $display("Covered %0d words in %0d lines: directed cases, zero and oversized screens,",
                 words_sent, lines_started);
        $display("three handshake mixes and lines whose rounding drifts past the edge");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
